/* design/assert_macros.svh */
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* design/bbws_pkg.sv */
// constants, control word type and microcode rom of the work splitter
`default_nettype none

package bbws_pkg;

    localparam int MAX_WORKERS    = 32;
    localparam int BLOCK_ELEMENTS = 8;
    localparam int BLOCK_SHIFT    = 3;

    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 6;
    localparam int INDEX_W  = 5;
    localparam int USED_W   = 6;
    localparam int QUO_W    = TOTAL_W - BLOCK_SHIFT;
    localparam int DIVCNT_W = 5;
    localparam int STEP_W   = 2;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CFG_W-1:0] WORKER_COUNT_RESET = 6'd8;

    localparam logic [STEP_W-1:0] STEP_LOAD   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_DIVIDE = 2'd1;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_RETURN = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV,
        ACT_EMIT
    } act_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        LOOP_NEVER,
        LOOP_ALWAYS,
        LOOP_DIV,
        LOOP_MORE
    } loop_t;

    typedef struct packed {
        act_t               act;
        hold_t              hold;
        loop_t              loop;
        logic [STEP_W-1:0]  target;
    } ctrl_word_t;

    // program: load, divide loop, emit loop, return to load
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] addr);
        ctrl_word_t cw;
        case (addr)
            STEP_LOAD:   cw = '{ACT_LOAD, HOLD_IN,   LOOP_NEVER,  STEP_LOAD};
            STEP_DIVIDE: cw = '{ACT_DIV,  HOLD_NONE, LOOP_DIV,    STEP_DIVIDE};
            STEP_EMIT:   cw = '{ACT_EMIT, HOLD_OUT,  LOOP_MORE,   STEP_EMIT};
            default:     cw = '{ACT_NONE, HOLD_NONE, LOOP_ALWAYS, STEP_LOAD};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* design/balanced_block_work_splitter_unit.sv */
// balanced block work splitter: microcoded divide and emit sequencer
//
// channel   direction  width  contents
// s_axis    in         32     tdata: total_elements
// m_axis    out        80     tdata: worker_index, start_offset, element_count,
//                             workers_used; tlast: last_worker
// cfg       in         6      worker_count write, always ready
//
// one split takes 1 load step, 29 divide steps (one quotient bit a cycle
// through the restoring divider), one emit step per worker used and one
// return step
// each emit step waits while the output register still holds an untaken word
// the next total is taken only in the load step
// reset clears the step counter and output valid and sets worker_count to 8
`default_nettype none

module balanced_block_work_splitter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // total_elements [31:0]
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // worker_index [4:0], start_offset [36:5], element_count [68:37],
    // workers_used [74:69], zero fill [79:75]
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic             m_axis_tlast,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);

`include "assert_macros.svh"

    // sequencer
    logic [bbws_pkg::STEP_W-1:0]   step_reg, step_next;
    bbws_pkg::ctrl_word_t          cw;
    logic                          fire;
    logic                          loop_taken;

    // configuration
    logic [bbws_pkg::CFG_W-1:0]    worker_count_reg;
    logic [bbws_pkg::USED_W-1:0]   eff_workers;

    // datapath
    logic [bbws_pkg::QUO_W-1:0]    quo_reg;       // blocks, then per-worker blocks
    logic [bbws_pkg::USED_W-1:0]   div_rem_reg;   // extra blocks once divided
    logic [bbws_pkg::DIVCNT_W-1:0] div_cnt_reg;
    logic [bbws_pkg::USED_W-1:0]   used_reg;
    logic [bbws_pkg::BLOCK_SHIFT-1:0] tail_reg;   // elements beyond the last block
    logic [bbws_pkg::INDEX_W-1:0]  k_reg;
    logic [bbws_pkg::TOTAL_W-1:0]  offset_reg;

    logic [bbws_pkg::QUO_W-1:0]    blocks_in;
    logic [bbws_pkg::USED_W-1:0]   used_in;
    logic [bbws_pkg::USED_W:0]     trial;
    logic                          trial_ge;
    logic                          last_now;
    logic [bbws_pkg::TOTAL_W-1:0]  count_now;
    logic                          out_free;

    // output register
    logic [bbws_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;

    assign cfg_ready = 1'b1;

    // zero workers act as one, anything above the maximum saturates
    always_comb
    begin
        if (worker_count_reg == '0)
            eff_workers = bbws_pkg::USED_W'(1);
        else if (worker_count_reg > bbws_pkg::USED_W'(bbws_pkg::MAX_WORKERS))
            eff_workers = bbws_pkg::USED_W'(bbws_pkg::MAX_WORKERS);
        else
            eff_workers = worker_count_reg;
    end

    // workers used: one with no whole block, the block count when it fits,
    // else all workers; dividing blocks by it covers every case
    assign blocks_in = s_axis_tdata[bbws_pkg::TOTAL_W-1:bbws_pkg::BLOCK_SHIFT];
    always_comb
    begin
        if (blocks_in == '0)
            used_in = bbws_pkg::USED_W'(1);
        else if (blocks_in <= bbws_pkg::QUO_W'(eff_workers))
            used_in = blocks_in[bbws_pkg::USED_W-1:0];
        else
            used_in = eff_workers;
    end

    // one restoring divide step
    assign trial    = {div_rem_reg, quo_reg[bbws_pkg::QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, used_reg});

    assign last_now = (({1'b0, k_reg} + bbws_pkg::USED_W'(1)) == used_reg);

    always_comb
    begin
        count_now = {quo_reg, {bbws_pkg::BLOCK_SHIFT{1'b0}}};
        if ({1'b0, k_reg} < div_rem_reg)
            count_now = count_now + bbws_pkg::TOTAL_W'(bbws_pkg::BLOCK_ELEMENTS);
        if (last_now)
            count_now = count_now + bbws_pkg::TOTAL_W'(tail_reg);
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // control word decode
    always_comb
    begin
        cw = bbws_pkg::ucode_rom(step_reg);
        case (cw.hold)
            bbws_pkg::HOLD_NONE: fire = 1'b1;
            bbws_pkg::HOLD_IN:   fire = s_axis_tvalid;
            bbws_pkg::HOLD_OUT:  fire = out_free;
            default:             fire = 1'b1;
        endcase
        case (cw.loop)
            bbws_pkg::LOOP_NEVER:  loop_taken = 1'b0;
            bbws_pkg::LOOP_ALWAYS: loop_taken = 1'b1;
            bbws_pkg::LOOP_DIV:    loop_taken = (div_cnt_reg != '0);
            bbws_pkg::LOOP_MORE:   loop_taken = !last_now;
            default:               loop_taken = 1'b0;
        endcase
        if (!fire)
            step_next = step_reg;
        else if (loop_taken)
            step_next = cw.target;
        else
            step_next = step_reg + bbws_pkg::STEP_W'(1);
    end

    assign s_axis_tready = (cw.hold == bbws_pkg::HOLD_IN);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= bbws_pkg::STEP_LOAD;
            worker_count_reg <= bbws_pkg::WORKER_COUNT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_valid)
                worker_count_reg <= cfg_data;
            if (fire && cw.act == bbws_pkg::ACT_EMIT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (cw.act)
                bbws_pkg::ACT_LOAD:
                begin
                    quo_reg     <= blocks_in;
                    div_rem_reg <= '0;
                    div_cnt_reg <= bbws_pkg::DIVCNT_W'(bbws_pkg::QUO_W - 1);
                    used_reg    <= used_in;
                    tail_reg    <= s_axis_tdata[bbws_pkg::BLOCK_SHIFT-1:0];
                    k_reg       <= '0;
                    offset_reg  <= '0;
                end
                bbws_pkg::ACT_DIV:
                begin
                    quo_reg <= {quo_reg[bbws_pkg::QUO_W-2:0], trial_ge};
                    if (trial_ge)
                        div_rem_reg <= bbws_pkg::USED_W'(trial - {1'b0, used_reg});
                    else
                        div_rem_reg <= trial[bbws_pkg::USED_W-1:0];
                    div_cnt_reg <= div_cnt_reg - bbws_pkg::DIVCNT_W'(1);
                end
                bbws_pkg::ACT_EMIT:
                begin
                    out_data_reg <= {{(bbws_pkg::OUT_TDATA_W - 75){1'b0}},
                                     used_reg, count_now, offset_reg, k_reg};
                    out_last_reg <= last_now;
                    offset_reg   <= offset_reg + count_now;
                    k_reg        <= k_reg + bbws_pkg::INDEX_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;

    // a taken total always starts the divide loop
    `ASSERT_NEXT(a_load_to_div, clk, rst_n, s_axis_tvalid && s_axis_tready,
                 step_reg == bbws_pkg::STEP_DIVIDE)
    // an emit step that fires leaves a word in the output register
    `ASSERT_NEXT(a_emit_fills_out, clk, rst_n,
                 step_reg == bbws_pkg::STEP_EMIT && out_free, m_axis_tvalid)
    // worker index stays below the number of workers used while emitting
    `ASSERT_IMPL(a_index_range, clk, rst_n, step_reg == bbws_pkg::STEP_EMIT,
                 {1'b0, k_reg} < used_reg)
    // divider remainder stays below the divisor while emitting
    `ASSERT_IMPL(a_rem_range, clk, rst_n, step_reg == bbws_pkg::STEP_EMIT,
                 div_rem_reg < used_reg)

endmodule

`default_nettype wire

/* tb/tb_balanced_block_work_splitter_unit.sv */
// self-checking testbench for the balanced block work splitter unit
`default_nettype none

module tb_balanced_block_work_splitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // one output word, split into its fields
    typedef struct {
        logic [bbws_pkg::INDEX_W-1:0] worker_index;
        logic [bbws_pkg::TOTAL_W-1:0] start_offset;
        logic [bbws_pkg::TOTAL_W-1:0] element_count;
        logic [bbws_pkg::USED_W-1:0]  workers_used;
        logic                         last_worker;
    } share_t;

    // a total on its way into the block, with its hand-written result if it has one
    typedef struct {
        bit                           single;
        logic [bbws_pkg::TOTAL_W-1:0] lone_count;
    } queued_total_t;

    // directed table: a register write, a total for the predictor, or a total
    // whose single share (worker 0, offset 0) is written out by hand
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_SINGLE
    } row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        logic [bbws_pkg::TOTAL_W-1:0] value;
        logic [bbws_pkg::TOTAL_W-1:0] lone_count;
    } row_t;

    localparam int DIR_ROWS      = 26;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 12;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 70;

    logic                               clk;
    logic                               rst_n;
    logic [bbws_pkg::TOTAL_W-1:0]       s_axis_tdata;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [bbws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic                               m_axis_tlast;
    logic [bbws_pkg::CFG_W-1:0]         cfg_data;
    logic                               cfg_valid;
    logic                               cfg_ready;

    // shares still owed by the block, oldest first
    share_t        expected_shares[$];
    // totals offered but not yet taken
    queued_total_t pending_totals[$];

    // worker_count as the block should hold it
    logic [bbws_pkg::CFG_W-1:0] model_workers = bbws_pkg::WORKER_COUNT_RESET;
    // worker_count last written by the stimulus side
    logic [bbws_pkg::CFG_W-1:0] cur_workers = bbws_pkg::WORKER_COUNT_RESET;

    int  error_count = 0;
    int  splits_seen = 0;
    int  shares_seen = 0;
    int  settings_used = 1;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    bit  hold_off_req = 1'b0;

    row_t dir_rows [DIR_ROWS];

    balanced_block_work_splitter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),   // total_elements [31:0]
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // worker_index, start_offset, element_count,
                                         // workers_used, zero fill
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),   // last_worker
        .cfg_data      (cfg_data),       // worker_count
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #4ms;
        $display("%0t: timeout", $time);
        $display("tb_balanced_block_work_splitter_unit NOT OK");
        $finish;
    end

    // -------------------------------------------------------------------------
    // predictor
    // -------------------------------------------------------------------------

    function automatic int unsigned usable_workers(input logic [bbws_pkg::CFG_W-1:0] wc);
        if (wc == 0)
            return 1;
        if (wc > bbws_pkg::MAX_WORKERS)
            return bbws_pkg::MAX_WORKERS;
        return wc;
    endfunction

    function automatic void push_share(input int unsigned k, input int unsigned offset,
                                       input int unsigned count, input int unsigned used);
        share_t s;
        s.worker_index  = k[bbws_pkg::INDEX_W-1:0];
        s.start_offset  = offset;
        s.element_count = count;
        s.workers_used  = used[bbws_pkg::USED_W-1:0];
        s.last_worker   = (k + 1 == used);
        expected_shares.push_back(s);
    endfunction

    // cut a total into whole blocks and deal them out, the leftover going to
    // the last worker used
    function automatic void split_total(input logic [bbws_pkg::TOTAL_W-1:0] total,
                                        input logic [bbws_pkg::CFG_W-1:0] wc);
        int unsigned workers;
        int unsigned blocks;
        int unsigned rem;
        int unsigned per;
        int unsigned extra;
        int unsigned count;
        int unsigned offset;
        workers = usable_workers(wc);
        blocks  = total / bbws_pkg::BLOCK_ELEMENTS;
        rem     = total % bbws_pkg::BLOCK_ELEMENTS;
        offset  = 0;
        if (blocks == 0)
        begin
            // nothing whole: worker 0 takes the lot
            push_share(0, 0, rem, 1);
        end
        else if (blocks <= workers)
        begin
            // one block each, leftover on the last
            for (int unsigned k = 0; k < blocks; k++)
                push_share(k, k * bbws_pkg::BLOCK_ELEMENTS,
                           bbws_pkg::BLOCK_ELEMENTS + ((k + 1 == blocks) ? rem : 0),
                           blocks);
        end
        else
        begin
            // even share, the first few take one block more
            per   = blocks / workers;
            extra = blocks % workers;
            for (int unsigned k = 0; k < workers; k++)
            begin
                count = per * bbws_pkg::BLOCK_ELEMENTS
                        + ((k < extra) ? bbws_pkg::BLOCK_ELEMENTS : 0);
                push_share(k, offset, count + ((k + 1 == workers) ? rem : 0), workers);
                offset += count;
            end
        end
    endfunction

    // -------------------------------------------------------------------------
    // checker: register writes, taken totals and returned words in one place
    // -------------------------------------------------------------------------

    task automatic check_field(input string name,
                               input logic [bbws_pkg::TOTAL_W-1:0] want,
                               input logic [bbws_pkg::TOTAL_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        share_t        got;
        share_t        want;
        queued_total_t qt;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model_workers = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                qt = pending_totals.pop_front();
                if (qt.single)
                    expected_shares.push_back('{'0, '0, qt.lone_count,
                                                bbws_pkg::USED_W'(1), 1'b1});
                else
                    split_total(s_axis_tdata, model_workers);
                splits_seen++;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.worker_index  = m_axis_tdata[4:0];
                got.start_offset  = m_axis_tdata[36:5];
                got.element_count = m_axis_tdata[68:37];
                got.workers_used  = m_axis_tdata[74:69];
                got.last_worker   = m_axis_tlast;
                shares_seen++;
                if (expected_shares.size() == 0)
                begin
                    error_count++;
                    $display("%0t: word with nothing expected, expected none, actual worker %0d",
                             $time, got.worker_index);
                end
                else
                begin
                    want = expected_shares.pop_front();
                    check_field("worker_index",  want.worker_index,  got.worker_index);
                    check_field("start_offset",  want.start_offset,  got.start_offset);
                    check_field("element_count", want.element_count, got.element_count);
                    check_field("workers_used",  want.workers_used,  got.workers_used);
                    check_field("last_worker",   want.last_worker,   got.last_worker);
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // -------------------------------------------------------------------------

    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                // block fills its output register and stops taking totals
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------------
    // sender side
    // -------------------------------------------------------------------------

    // offer one total and hold it until taken; valid stays high afterwards
    task automatic offer_total(input logic [bbws_pkg::TOTAL_W-1:0] total, input bit single,
                               input logic [bbws_pkg::TOTAL_W-1:0] lone_count);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        pending_totals.push_back('{single, lone_count});
        s_axis_tdata  <= total;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // wait for every owed word, then let the return step go by
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (expected_shares.size() != 0 || pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // worker_count may change only while the block is idle
    task automatic write_workers(input logic [bbws_pkg::CFG_W-1:0] wc);
        drain_block();
        cfg_data  <= wc;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        cur_workers = wc;
        settings_used++;
    endtask

    function automatic logic [bbws_pkg::CFG_W-1:0] pick_workers();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return bbws_pkg::CFG_W'(1);
            2:       return bbws_pkg::CFG_W'(bbws_pkg::MAX_WORKERS);
            3:       return bbws_pkg::CFG_W'($urandom_range(bbws_pkg::MAX_WORKERS + 1, 63));
            default: return bbws_pkg::CFG_W'($urandom_range(2, bbws_pkg::MAX_WORKERS - 1));
        endcase
    endfunction

    // totals near the block and worker boundaries or the top of the range, within three worker spans, or anywhere
    function automatic logic [bbws_pkg::TOTAL_W-1:0] pick_total(
        input logic [bbws_pkg::CFG_W-1:0] wc);
        int unsigned span;
        span = usable_workers(wc) * bbws_pkg::BLOCK_ELEMENTS;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2 * bbws_pkg::BLOCK_ELEMENTS - 1);
            1, 2, 3: return $urandom_range(0, 3 * span);
            4:       return span * $urandom_range(1, 4)
                            + $urandom_range(0, bbws_pkg::BLOCK_ELEMENTS - 1);
            5, 6, 7: return $urandom;
            8:       return $urandom >> $urandom_range(0, 31);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    initial
    begin
        // zeros and single shares are written out; the rest goes to the predictor
        dir_rows = '{
            '{ROW_SINGLE,  32'd0,          32'd0},
            '{ROW_SINGLE,  32'd7,          32'd7},
            '{ROW_SINGLE,  32'd8,          32'd8},
            '{ROW_SINGLE,  32'd15,         32'd15},
            '{ROW_PREDICT, 32'd16,         32'd0},
            '{ROW_PREDICT, 32'd64,         32'd0},
            '{ROW_PREDICT, 32'd71,         32'd0},
            '{ROW_PREDICT, 32'd100,        32'd0},
            '{ROW_PREDICT, 32'hFFFF_FFFF,  32'd0},
            '{ROW_PREDICT, 32'h8000_0000,  32'd0},
            '{ROW_CFG,     32'd0,          32'd0},   // zero workers act as one
            '{ROW_SINGLE,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
            '{ROW_SINGLE,  32'd20,         32'd20},
            '{ROW_CFG,     32'd1,          32'd0},
            '{ROW_SINGLE,  32'd5,          32'd5},
            '{ROW_SINGLE,  32'd1000,       32'd1000},
            '{ROW_CFG,     32'd32,         32'd0},
            '{ROW_PREDICT, 32'd256,        32'd0},   // exactly one block per worker
            '{ROW_PREDICT, 32'd263,        32'd0},
            '{ROW_PREDICT, 32'd264,        32'd0},   // one block more than workers
            '{ROW_PREDICT, 32'hFFFF_FFFF,  32'd0},
            '{ROW_CFG,     32'd63,         32'd0},   // saturates to the maximum
            '{ROW_PREDICT, 32'hFFFF_FFFF,  32'd0},
            '{ROW_PREDICT, 32'd255,        32'd0},
            '{ROW_CFG,     32'd33,         32'd0},
            '{ROW_PREDICT, 32'd1234567,    32'd0}
        };

        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        cfg_data      <= '0;
        cfg_valid     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, starting from the reset worker count
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_workers(dir_rows[i].value[bbws_pkg::CFG_W-1:0]);
            else
                offer_total(dir_rows[i].value, dir_rows[i].kind == ROW_SINGLE,
                            dir_rows[i].lone_count);
        end

        // random part, one worker setting per phase
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_workers(pick_workers());
            if (p == RAND_PHASES - 1)
            begin
                // closing phase runs flat out
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            else if (p == PRESSURE_PHASE)
            begin
                // keep offering while the receiver sits on its hands
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b1;
                hold_off_req = 1'b1;
            end
            else
            begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_total(pick_total(cur_workers), 1'b0, '0);
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d splits and %0d returned words over %0d worker settings,",
                 splits_seen, shares_seen, settings_used);
        $display("zero, one, full and saturating worker counts, with a long output hold-off");
        if (error_count == 0)
            $display("tb_balanced_block_work_splitter_unit OK");
        else
            $display("tb_balanced_block_work_splitter_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/bbws_pkg.sv
design/balanced_block_work_splitter_unit.sv
tb/tb_balanced_block_work_splitter_unit.sv
